// File: hdl/c8ie_pkg.sv
// Package: types, codes and helpers shared by the CHIP-8 execute block.
`default_nettype none
package c8ie_pkg;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int MEM_BYTES_DEF   = 4096;
  localparam logic [11:0] PC_RESET = 12'h200;

  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_DRAW  = 2'd2;
  localparam logic [1:0] REQ_SOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] instruction;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [7:0]  random_byte;
    logic [3:0]  key_code;
    logic        key_down;
    logic [7:0]  delay_value;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [15:0] index_value;
    logic [1:0]  controller_request;
    logic [7:0]  reg_x_value;
    logic [7:0]  reg_y_value;
    logic        delay_write;
    logic [7:0]  delay_write_value;
    logic        waiting_key;
    logic        illegal;
    logic [7:0]  read_data;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_BCD1, ST_BCD2, ST_STORE, ST_LREQ, ST_LOAD, ST_MRD, ST_OUT
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_item;   // capture input beat
    logic exec;        // run instruction work
    logic bcd1;        // write tens digit
    logic bcd2;        // write ones digit
    logic store_step;  // write V[cnt] to memory
    logic load_req;    // issue memory read for V[cnt]
    logic load_step;   // write read data into V[cnt]
    logic mem_read;    // issue read for op read
    logic finish;      // latch result
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [1:0] op;
    logic       is_bcd;
    logic       is_store;
    logic       is_load;
    logic       cnt_last;
  } stat_t;

  // Decimal digits of a byte via small multiplications by reciprocal.
  function automatic logic [3:0] hundreds(input logic [7:0] v);
    logic [15:0] p;
    p = v * 16'd41;
    return p[15:12];
  endfunction

  function automatic logic [7:0] rem100(input logic [7:0] v);
    return v - 8'(hundreds(v) * 8'd100);
  endfunction

  function automatic logic [3:0] tens(input logic [7:0] r);
    logic [15:0] p;
    p = r * 16'd205;
    return p[14:11];
  endfunction
endpackage
`default_nettype wire

// File: hdl/chip8_instruction_execute.sv
// Top level of the CHIP-8 instruction execute block.
// Each input beat either runs one CHIP-8 opcode or reads/writes one byte of
// the 4 KB memory, and yields exactly one result beat with PC, index, VX/VY
// and side requests. One beat is in flight at a time. Fx33, Fx55, Fx65 and
// memory reads hold the block longer than other opcodes, set by the single
// memory port walking the registers one byte per access (read data is
// registered, so each load is a request state then a write-back state). The
// result is valid in the cycle after the output state finishes the beat. It
// sits in an output register, so a stalled consumer only delays the next
// beat.
// Clear, draw and sound are signalled on controller_request only.
`default_nettype none
module chip8_instruction_execute #(
  parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF,
  parameter int MEM_BYTES   = c8ie_pkg::MEM_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire c8ie_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output c8ie_pkg::out_beat_t      out_data
);
  c8ie_pkg::cmd_t  cmd;
  c8ie_pkg::stat_t stat;

  // sequencer
  c8ie_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  // state and execution units
  c8ie_datapath #(.STACK_DEPTH(STACK_DEPTH), .MEM_BYTES(MEM_BYTES)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .stat, .out_data
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("beat dropped");
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken");
  a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish)) else $error("result without beat");
endmodule
`default_nettype wire

// File: hdl/c8ie_ctrl.sv
// Controller state machine sequencing each beat through the datapath.
`default_nettype none
module c8ie_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire c8ie_pkg::stat_t stat,
  output c8ie_pkg::cmd_t      cmd
);
  c8ie_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= c8ie_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      c8ie_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt = c8ie_pkg::ST_EXEC;
        end
      end
      c8ie_pkg::ST_EXEC: begin
        if (stat.op == c8ie_pkg::OP_READ) begin
          cmd.mem_read = 1'b1;
          state_nxt = c8ie_pkg::ST_MRD;
        end else if (stat.is_bcd) begin
          cmd.exec = 1'b1;
          state_nxt = c8ie_pkg::ST_BCD1;
        end else if (stat.is_store) begin
          state_nxt = c8ie_pkg::ST_STORE;
        end else if (stat.is_load) begin
          state_nxt = c8ie_pkg::ST_LREQ;
        end else begin
          cmd.exec = 1'b1;
          state_nxt = c8ie_pkg::ST_OUT;
        end
      end
      c8ie_pkg::ST_BCD1: begin
        cmd.bcd1 = 1'b1;
        state_nxt = c8ie_pkg::ST_BCD2;
      end
      c8ie_pkg::ST_BCD2: begin
        cmd.bcd2 = 1'b1;
        state_nxt = c8ie_pkg::ST_OUT;
      end
      c8ie_pkg::ST_STORE: begin
        cmd.store_step = 1'b1;
        if (stat.cnt_last) begin
          cmd.exec = 1'b1;
          state_nxt = c8ie_pkg::ST_OUT;
        end
      end
      c8ie_pkg::ST_LREQ: begin
        cmd.load_req = 1'b1;
        state_nxt = c8ie_pkg::ST_LOAD;
      end
      c8ie_pkg::ST_LOAD: begin
        cmd.load_step = 1'b1;
        if (stat.cnt_last) begin
          cmd.exec = 1'b1;
          state_nxt = c8ie_pkg::ST_OUT;
        end else begin
          state_nxt = c8ie_pkg::ST_LREQ;
        end
      end
      c8ie_pkg::ST_MRD: begin
        state_nxt = c8ie_pkg::ST_OUT;
      end
      c8ie_pkg::ST_OUT: begin
        // wait until output register is free
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = c8ie_pkg::ST_IDLE;
        end
      end
      default: state_nxt = c8ie_pkg::ST_IDLE;
    endcase
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != c8ie_pkg::ST_IDLE |-> !in_ready) else $error("ready while busy");
  a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("finish lost");
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == c8ie_pkg::ST_EXEC) else $error("accept path");
endmodule
`default_nettype wire

// File: hdl/c8ie_datapath.sv
// Datapath: register file, PC, index, return stack, byte memory and result register.
`default_nettype none
module c8ie_datapath #(
  parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF,
  parameter int MEM_BYTES   = c8ie_pkg::MEM_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire c8ie_pkg::in_beat_t in_data,
  input  wire c8ie_pkg::cmd_t     cmd,
  output c8ie_pkg::stat_t         stat,
  output c8ie_pkg::out_beat_t     out_data
);
  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int AW  = $clog2(MEM_BYTES);

  c8ie_pkg::in_beat_t item_r;
  logic [11:0] pc_r;
  logic [15:0] idx_r;
  logic [7:0]  v_r [16];
  logic [SPW-1:0] sp_r;
  logic [11:0] stk [STACK_DEPTH];
  logic [7:0]  mem [MEM_BYTES];
  logic        err_r;
  logic [3:0]  cnt_r;
  logic [7:0]  rd_r;
  logic [1:0]  req_r;
  logic        dw_r, wait_r;
  logic [7:0]  dwv_r;
  c8ie_pkg::out_beat_t out_r;

  logic [15:0] ins;
  logic [3:0]  x, y, n;
  logic [7:0]  nn, vx, vy;
  logic [11:0] nnn;
  assign ins = item_r.instruction;
  assign x = ins[11:8];
  assign y = ins[7:4];
  assign n = ins[3:0];
  assign nn = ins[7:0];
  assign nnn = ins[11:0];
  assign vx = v_r[x];
  assign vy = v_r[y];

  logic exe;
  assign exe = item_r.op == c8ie_pkg::OP_EXEC;
  assign stat.op       = item_r.op;
  assign stat.is_bcd   = exe && ins[15:12] == 4'hF && nn == 8'h33;
  assign stat.is_store = exe && ins[15:12] == 4'hF && nn == 8'h55;
  assign stat.is_load  = exe && ins[15:12] == 4'hF && nn == 8'h65;
  assign stat.cnt_last = cnt_r == x;

  // memory port: one write, one registered read
  logic          mwe;
  logic [AW-1:0] mwa, mra;
  logic [7:0]    mwd;
  logic [7:0]    rem;
  assign rem = c8ie_pkg::rem100(vx);

  always_comb begin
    mwe = 1'b0;
    mwa = AW'(idx_r);
    mwd = vx;
    mra = AW'(idx_r + 16'(cnt_r));
    if (item_r.op == c8ie_pkg::OP_WRITE && cmd.exec) begin
      mwe = 1'b1;
      mwa = AW'(item_r.address);
      mwd = item_r.write_data;
    end else if (cmd.exec && stat.is_bcd) begin
      mwe = 1'b1;
      mwd = 8'(c8ie_pkg::hundreds(vx));
    end else if (cmd.bcd1) begin
      mwe = 1'b1;
      mwa = AW'(idx_r + 16'd1);
      mwd = 8'(c8ie_pkg::tens(rem));
    end else if (cmd.bcd2) begin
      mwe = 1'b1;
      mwa = AW'(idx_r + 16'd2);
      mwd = rem - 8'(c8ie_pkg::tens(rem) * 4'd10);
    end else if (cmd.store_step) begin
      mwe = 1'b1;
      mwa = AW'(idx_r + 16'(cnt_r));
      mwd = v_r[cnt_r];
    end
    if (cmd.mem_read) mra = AW'(item_r.address);
  end

  // read data is held until the next requested read
  always_ff @(posedge clk) begin
    if (mwe) mem[mwa] <= mwd;
    if (cmd.mem_read || cmd.load_req) rd_r <= mem[mra];
  end

  // execute
  logic [11:0] pc_nxt;
  logic [15:0] idx_nxt;
  logic [SPW-1:0] sp_nxt;
  logic        push, bad, skip, adv, vx_we, vf_we;
  logic [7:0]  vx_nxt, vf_nxt;
  logic [7:0]  vxa, vya;
  logic [1:0]  req_nxt;
  logic        dw_nxt, wait_nxt;
  logic [8:0]  sum;
  logic [7:0]  vx_f;

  always_comb begin
    pc_nxt = pc_r; idx_nxt = idx_r; sp_nxt = sp_r;
    push = 1'b0; bad = 1'b0; skip = 1'b0; adv = 1'b1;
    vx_we = 1'b0; vf_we = 1'b0; vx_nxt = vx; vf_nxt = 8'd0;
    vxa = vx; vya = vy;
    req_nxt = c8ie_pkg::REQ_NONE; dw_nxt = 1'b0; wait_nxt = 1'b0;
    sum = 9'(vx) + 9'(vy);
    case (ins[15:12])
      4'h0: begin
        if (ins == 16'h00E0) req_nxt = c8ie_pkg::REQ_CLEAR;
        else if (ins == 16'h00EE) begin
          sp_nxt = (sp_r == '0) ? SPW'(STACK_DEPTH - 1) : sp_r - 1'b1;
          pc_nxt = stk[sp_nxt];
        end else bad = 1'b1;
      end
      4'h1: begin pc_nxt = nnn; adv = 1'b0; end
      4'h2: begin
        push = 1'b1;
        sp_nxt = (32'(sp_r) + 1 >= STACK_DEPTH) ? '0 : sp_r + 1'b1;
        pc_nxt = nnn; adv = 1'b0;
      end
      4'h3: skip = vx == nn;
      4'h4: skip = vx != nn;
      4'h5: if (n != 4'd0) bad = 1'b1; else skip = vx == vy;
      4'h6: begin vx_we = 1'b1; vx_nxt = nn; end
      4'h7: begin vx_we = 1'b1; vx_nxt = vx + nn; end
      4'h8: begin
        vx_we = 1'b1;
        case (n)
          4'h4: begin vf_we = 1'b1; vf_nxt = {7'd0, sum[8]}; end
          4'h5: begin vf_we = 1'b1; vf_nxt = {7'd0, !(vx < vy)}; end
          4'h6: begin vf_we = 1'b1; vf_nxt = {7'd0, vx[0]}; end
          4'h7: begin vf_we = 1'b1; vf_nxt = {7'd0, !(vy < vx)}; end
          4'hE: begin vf_we = 1'b1; vf_nxt = {7'd0, vx[7]}; end
          default: ;
        endcase
        // flag lands first: an operand named F sees the new flag
        vxa = (vf_we && x == 4'hF) ? vf_nxt : vx;
        vya = (vf_we && y == 4'hF) ? vf_nxt : vy;
        case (n)
          4'h0: vx_nxt = vya;
          4'h1: vx_nxt = vxa | vya;
          4'h2: vx_nxt = vxa & vya;
          4'h3: vx_nxt = vxa ^ vya;
          4'h4: vx_nxt = vxa + vya;
          4'h5: vx_nxt = vxa - vya;
          4'h6: vx_nxt = vxa >> 1;
          4'h7: vx_nxt = vya - vxa;
          4'hE: vx_nxt = vxa << 1;
          default: begin vx_we = 1'b0; bad = 1'b1; end
        endcase
        // with X = F the ALU result wins
        if (vf_we && x == 4'hF) vf_we = 1'b0;
      end
      4'h9: if (n != 4'd0) bad = 1'b1; else skip = vx != vy;
      4'hA: idx_nxt = {4'd0, nnn};
      4'hB: begin pc_nxt = nnn + 12'(v_r[0]); adv = 1'b0; end
      4'hC: begin vx_we = 1'b1; vx_nxt = item_r.random_byte & nn; end
      4'hD: req_nxt = c8ie_pkg::REQ_DRAW;
      4'hE: begin
        if (nn == 8'h9E) skip = item_r.key_down && {4'd0, item_r.key_code} == vx;
        else if (nn == 8'hA1) skip = !(item_r.key_down && {4'd0, item_r.key_code} == vx);
        else bad = 1'b1;
      end
      default: begin
        case (nn)
          8'h07: begin vx_we = 1'b1; vx_nxt = item_r.delay_value; end
          8'h0A: begin
            if (item_r.key_down) begin vx_we = 1'b1; vx_nxt = {4'd0, item_r.key_code}; end
            else begin adv = 1'b0; wait_nxt = 1'b1; end
          end
          8'h15: dw_nxt = 1'b1;
          8'h18: req_nxt = c8ie_pkg::REQ_SOUND;
          8'h1E: idx_nxt = idx_r + 16'(vx);
          8'h29: idx_nxt = 16'(vx) * 16'd5;
          8'h33, 8'h55, 8'h65: ;
          default: bad = 1'b1;
        endcase
      end
    endcase
    if (skip) pc_nxt = pc_nxt + 12'd2;
    if (adv)  pc_nxt = pc_nxt + 12'd2;
  end

  logic go;
  assign go = cmd.exec && exe;
  assign vx_f = vx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= c8ie_pkg::PC_RESET;
      idx_r <= '0;
      sp_r  <= '0;
      err_r <= 1'b0;
      for (int i = 0; i < 16; i++) v_r[i] <= '0;
    end else begin
      if (go) begin
        pc_r  <= pc_nxt;
        idx_r <= idx_nxt;
        sp_r  <= sp_nxt;
        if (bad) err_r <= 1'b1;
        if (vf_we) v_r[15] <= vf_nxt;
        if (vx_we) v_r[x] <= vx_f;
      end
      if (cmd.load_step) v_r[cnt_r] <= rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go && push) stk[sp_r] <= pc_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
      cnt_r  <= '0;
    end else if (cmd.store_step || cmd.load_step) begin
      cnt_r <= cnt_r + 4'd1;
    end
    if (go) begin
      req_r  <= req_nxt;
      dw_r   <= dw_nxt;
      dwv_r  <= dw_nxt ? vx : 8'd0;
      wait_r <= wait_nxt;
    end else if (cmd.load_item) begin
      req_r <= c8ie_pkg::REQ_NONE; dw_r <= 1'b0; dwv_r <= '0; wait_r <= 1'b0;
    end
    if (cmd.finish) begin
      out_r.next_pc            <= pc_r;
      out_r.index_value        <= idx_r;
      out_r.controller_request <= req_r;
      out_r.reg_x_value        <= vx;
      out_r.reg_y_value        <= vy;
      out_r.delay_write        <= dw_r;
      out_r.delay_write_value  <= dwv_r;
      out_r.waiting_key        <= wait_r;
      out_r.illegal            <= err_r;
      out_r.read_data          <= (item_r.op == c8ie_pkg::OP_READ) ? rd_r : 8'd0;
    end
  end

  assign out_data = out_r;

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r) else $error("error flag dropped");
  a_mem_no_pc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && !exe |=> $stable(pc_r)) else $error("memory beat moved pc");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_step || cmd.load_step |-> cnt_r <= x) else $error("walk overran");
endmodule
`default_nettype wire
